[design/awm_pkg.sv]
// shared constants, types and codes for the anagram window matcher
`timescale 1ns / 1ps
`default_nettype none

package awm_pkg;

    localparam int ALPHABET    = 26;
    localparam int LETTER_W    = 5;
    localparam int BAL_W       = 8;
    localparam int PATTERN_MAX = 64;
    localparam int PTR_W       = 6;
    localparam int SIZE_W      = 7;
    localparam int POS_W       = 20;
    localparam int COUNT_W     = 20;

    localparam logic [SIZE_W-1:0]  SIZE_MAX  = SIZE_W'(PATTERN_MAX);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_PATTERN = 2'd1,
        FUNC_TEXT    = 2'd2
    } func_t;

    // balance update requested for one item
    typedef struct packed {
        logic                clear;
        logic                inc_en;
        logic [LETTER_W-1:0] inc_letter;
        logic                dec_en;
        logic [LETTER_W-1:0] dec_letter;
        logic                leave_en;
        logic [LETTER_W-1:0] leave_letter;
    } bal_ctrl_t;

endpackage

`default_nettype wire

[design/awm_balance.sv]
// per-letter balance counters with the all-zero check
`timescale 1ns / 1ps
`default_nettype none

module awm_balance
    import awm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      update,
    input  bal_ctrl_t      ctrl,
    output logic           zero_after_dec
);

    logic signed [BAL_W-1:0] bal_reg  [ALPHABET];
    logic signed [BAL_W-1:0] bal_next [ALPHABET];
    logic signed [BAL_W-1:0] bal_dec  [ALPHABET];
    logic [ALPHABET-1:0]     nonzero;

    always_comb begin
        for (int k = 0; k < ALPHABET; k++) begin
            bal_dec[k] = bal_reg[k];
            if (ctrl.dec_en && ctrl.dec_letter == LETTER_W'(k)) begin
                bal_dec[k] = bal_reg[k] - BAL_W'(1);
            end
            nonzero[k] = (bal_dec[k] != '0);
            bal_next[k] = bal_dec[k];
            if (ctrl.inc_en && ctrl.inc_letter == LETTER_W'(k)) begin
                bal_next[k] = bal_next[k] + BAL_W'(1);
            end
            // letter leaving the window goes back after the check
            if (ctrl.leave_en && ctrl.leave_letter == LETTER_W'(k)) begin
                bal_next[k] = bal_next[k] + BAL_W'(1);
            end
        end
    end

    assign zero_after_dec = ~|nonzero;

    always_ff @(posedge aclk) begin
        for (int k = 0; k < ALPHABET; k++) begin
            if (!aresetn) begin
                bal_reg[k] <= '0;
            end else if (update) begin
                bal_reg[k] <= ctrl.clear ? '0 : bal_next[k];
            end
        end
    end

endmodule

`default_nettype wire

[design/anagram_window_match.sv]
// top level: streaming anagram search over a sliding window of text letters
//
//  channel  | direction | ports                                        | handshake
//  s_       | in        | s_func[1:0], s_letter[4:0]                   | s_valid / s_ready
//  m_       | out       | m_match, m_window_start[19:0], m_match_total | m_valid / m_ready
//
// one item per cycle sustained while m_ready is high; an accepted item goes through the
// input register, then the balance update and zero check into the result register
// aresetn clears the balances, counters and handshake state; the 64-entry delay
// line is not cleared, its entries are only read once written since the last clear
// with m_ready low the result register holds and one more item waits in the input register

`timescale 1ns / 1ps
`default_nettype none

module anagram_window_match
    import awm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_func,
    input  wire logic [LETTER_W-1:0] s_letter,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_match,
    output logic [POS_W-1:0]         m_window_start,
    output logic [COUNT_W-1:0]       m_match_total
);

    // input register
    logic                in_valid_reg;
    logic [1:0]          in_func_reg;
    logic [LETTER_W-1:0] in_letter_reg;

    // result register
    logic                m_valid_reg;
    logic                m_match_reg;
    logic [POS_W-1:0]    m_start_reg;
    logic [COUNT_W-1:0]  m_total_reg;

    // block state
    logic [SIZE_W-1:0]   pattern_size_reg, pattern_size_next;
    logic [SIZE_W-1:0]   window_fill_reg, window_fill_next;
    logic [POS_W-1:0]    text_position_reg, text_position_next;
    logic [COUNT_W-1:0]  match_count_reg, match_count_next;
    logic                text_begun_reg, text_begun_next;
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;

    // delay line
    logic [LETTER_W-1:0] recent_mem [PATTERN_MAX];
    logic [LETTER_W-1:0] leave_rd_reg;
    logic [PTR_W-1:0]    rd_addr;

    logic                advance;
    logic                letter_ok;
    logic                is_clear;
    logic                is_pattern;
    logic                is_text;
    logic                text_active;
    logic [SIZE_W-1:0]   fill_inc;
    logic                window_full;
    logic                zero_after_dec;
    logic                hit;
    logic [LETTER_W-1:0] leave_letter;
    logic [POS_W-1:0]    start_calc;
    bal_ctrl_t           bal_ctrl;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_func_reg   <= s_func;
            in_letter_reg <= s_letter;
        end
    end

    // item decode
    assign letter_ok   = (in_letter_reg < LETTER_W'(ALPHABET));
    assign is_clear    = (in_func_reg == FUNC_CLEAR);
    assign is_pattern  = (in_func_reg == FUNC_PATTERN) && letter_ok && !text_begun_reg
                         && (pattern_size_reg < SIZE_MAX);
    assign is_text     = (in_func_reg == FUNC_TEXT) && letter_ok;
    assign text_active = is_text && (pattern_size_reg != '0);

    assign fill_inc    = (window_fill_reg < pattern_size_reg)
                         ? window_fill_reg + SIZE_W'(1) : window_fill_reg;
    assign window_full = text_active && (fill_inc == pattern_size_reg);
    assign hit         = window_full && zero_after_dec;

    // with a one-letter pattern the leaving letter is the one just taken
    assign leave_letter = (pattern_size_reg == SIZE_W'(1)) ? in_letter_reg : leave_rd_reg;

    assign start_calc = text_position_reg - POS_W'(pattern_size_reg) + POS_W'(1);

    always_comb begin
        bal_ctrl.clear        = is_clear;
        bal_ctrl.inc_en       = is_pattern;
        bal_ctrl.inc_letter   = in_letter_reg;
        bal_ctrl.dec_en       = text_active;
        bal_ctrl.dec_letter   = in_letter_reg;
        bal_ctrl.leave_en     = window_full;
        bal_ctrl.leave_letter = leave_letter;
    end

    awm_balance u_balance (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .update         (advance),
        .ctrl           (bal_ctrl),
        .zero_after_dec (zero_after_dec)
    );

    always_comb begin
        pattern_size_next  = pattern_size_reg;
        window_fill_next   = window_fill_reg;
        text_position_next = text_position_reg;
        match_count_next   = match_count_reg;
        text_begun_next    = text_begun_reg;
        wr_ptr_next        = wr_ptr_reg;
        if (advance) begin
            if (is_clear) begin
                pattern_size_next  = '0;
                window_fill_next   = '0;
                text_position_next = '0;
                match_count_next   = '0;
                text_begun_next    = 1'b0;
                wr_ptr_next        = '0;
            end else if (is_pattern) begin
                pattern_size_next = pattern_size_reg + SIZE_W'(1);
            end else if (is_text) begin
                text_begun_next    = 1'b1;
                text_position_next = text_position_reg + POS_W'(1);
                if (text_active) begin
                    window_fill_next = fill_inc;
                    wr_ptr_next      = wr_ptr_reg + PTR_W'(1);
                    if (hit && match_count_reg != COUNT_MAX) begin
                        match_count_next = match_count_reg + COUNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_size_reg  <= '0;
            window_fill_reg   <= '0;
            text_position_reg <= '0;
            match_count_reg   <= '0;
            text_begun_reg    <= 1'b0;
            wr_ptr_reg        <= '0;
        end else begin
            pattern_size_reg  <= pattern_size_next;
            window_fill_reg   <= window_fill_next;
            text_position_reg <= text_position_next;
            match_count_reg   <= match_count_next;
            text_begun_reg    <= text_begun_next;
            wr_ptr_reg        <= wr_ptr_next;
        end
    end

    // read ahead the letter that leaves on the next text item
    assign rd_addr = wr_ptr_next + PTR_W'(1) - pattern_size_next[PTR_W-1:0];

    always_ff @(posedge aclk) begin
        if (advance && text_active) begin
            recent_mem[wr_ptr_reg] <= in_letter_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && text_active && rd_addr == wr_ptr_reg) begin
            leave_rd_reg <= in_letter_reg;
        end else begin
            leave_rd_reg <= recent_mem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_match_reg <= hit;
            m_start_reg <= window_full ? start_calc : '0;
            m_total_reg <= match_count_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_match        = m_match_reg;
    assign m_window_start = m_start_reg;
    assign m_match_total  = m_total_reg;

    // a reported match always leaves a non-zero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_match_reg) |-> (m_total_reg != '0))
        else $error("match reported with zero match total");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (window_fill_reg <= pattern_size_reg) && (pattern_size_reg <= SIZE_MAX))
        else $error("window fill or pattern size out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !text_begun_reg |-> (window_fill_reg == '0))
        else $error("window filled before any text item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_valid_reg && !m_ready) |=> $stable(m_start_reg))
        else $error("result changed while stalled");

endmodule

`default_nettype wire

[tb/sv/anagram_window_match_tb.sv]
// testbench for the anagram window matcher: random stimulus, self-checking against a predictor
`timescale 1ns / 1ps

module anagram_window_match_tb;
    import awm_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]          func;
        logic [LETTER_W-1:0] letter;
        int                  phase;
        bit                  drain;
    } letter_item_t;

    typedef struct packed {
        logic               match;
        logic [POS_W-1:0]   window_start;
        logic [COUNT_W-1:0] match_total;
    } verdict_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_valid  = 1'b0;
    logic [1:0]          s_func   = '0;
    logic [LETTER_W-1:0] s_letter = '0;
    logic                m_ready  = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic                m_match;
    logic [POS_W-1:0]    m_window_start;
    logic [COUNT_W-1:0]  m_match_total;

    letter_item_t letter_q [$];
    letter_item_t next_item;
    verdict_t     verdict_q [$];
    verdict_t     seen;
    int           phase_now = 0;
    int unsigned  fails = 0;

    // idle percentages per phase
    int send_idle [3] = '{19, 87, 0};
    int recv_idle [3] = '{87, 19, 0};

    // predictor state
    logic signed [BAL_W-1:0] tally [ALPHABET];
    logic [LETTER_W-1:0]     history [PATTERN_MAX];
    logic [SIZE_W-1:0]       pat_len;
    logic [SIZE_W-1:0]       win_fill;
    logic [POS_W-1:0]        txt_pos;
    logic [COUNT_W-1:0]      hits;
    logic                    text_seen;

    anagram_window_match dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_letter       (s_letter),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match        (m_match),
        .m_window_start (m_window_start),
        .m_match_total  (m_match_total)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void clear_tally();
        int k;
        for (k = 0; k < ALPHABET; k++) tally[k] = '0;
        for (k = 0; k < PATTERN_MAX; k++) history[k] = '0;
        pat_len   = '0;
        win_fill  = '0;
        txt_pos   = '0;
        hits      = '0;
        text_seen = 1'b0;
    endfunction

    function automatic verdict_t window_verdict(logic [1:0] func, logic [LETTER_W-1:0] letter);
        verdict_t            v;
        logic [LETTER_W-1:0] leaving;
        logic                balanced;
        int                  k;
        v = '0;
        if (func == FUNC_CLEAR) begin
            clear_tally();
        end else if (letter < ALPHABET) begin
            if (func == FUNC_PATTERN) begin
                if (!text_seen && pat_len < SIZE_MAX) begin
                    tally[letter] = tally[letter] + 8'sd1;
                    pat_len = pat_len + 1'b1;
                end
            end else if (func == FUNC_TEXT) begin
                text_seen = 1'b1;
                if (pat_len != 0) begin
                    tally[letter] = tally[letter] - 8'sd1;
                    for (k = PATTERN_MAX - 1; k > 0; k--) history[k] = history[k-1];
                    history[0] = letter;
                    if (win_fill < pat_len) win_fill = win_fill + 1'b1;
                    if (win_fill == pat_len) begin
                        balanced = 1'b1;
                        for (k = 0; k < ALPHABET; k++)
                            if (tally[k] != 0) balanced = 1'b0;
                        if (balanced) begin
                            v.match = 1'b1;
                            if (hits != COUNT_MAX) hits = hits + 1'b1;
                        end
                        v.window_start = txt_pos - POS_W'(pat_len) + 1'b1;
                        // letter dropping out of the window goes back into its tally
                        leaving = history[PTR_W'(pat_len - 7'd1)];
                        tally[leaving] = tally[leaving] + 8'sd1;
                    end
                end
                txt_pos = txt_pos + 1'b1;
            end
        end
        v.match_total = hits;
        return v;
    endfunction

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fails++;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            clear_tally();
        end else begin
            if (s_valid && s_ready)
                verdict_q.insert(verdict_q.size(), window_verdict(s_func, s_letter));
            if (!s_valid || s_ready) begin
                if (letter_q.size() != 0
                    && !(letter_q[0].drain && verdict_q.size() != 0)
                    && $urandom_range(99) >= send_idle[letter_q[0].phase]) begin
                    next_item = letter_q[0];
                    letter_q.delete(0);
                    s_valid   <= 1'b1;
                    s_func    <= next_item.func;
                    s_letter  <= next_item.letter;
                    phase_now <= next_item.phase;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result with no item outstanding");
                    fails++;
                end else begin
                    seen = verdict_q[0];
                    verdict_q.delete(0);
                    check_field("match", seen.match, m_match);
                    check_field("window_start", seen.window_start, m_window_start);
                    check_field("match_total", seen.match_total, m_match_total);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle[phase_now]);
        end
    end

    task automatic add_item(logic [1:0] func, logic [LETTER_W-1:0] letter, int phase,
                            bit drain);
        letter_item_t it;
        it.func   = func;
        it.letter = letter;
        it.phase  = phase;
        it.drain  = drain;
        letter_q.insert(letter_q.size(), it);
    endtask

    // clear, a pattern, then text mixing shuffled copies of the pattern, near misses and noise
    task automatic add_sequence(int phase, bit hold);
        logic [LETTER_W-1:0] pat [$];
        logic [LETTER_W-1:0] swap;
        int plen, span, base, tlen, sent, pick, i, j;
        add_item(FUNC_CLEAR, LETTER_W'($urandom_range(31)), phase,
                 hold || ($urandom_range(99) < 4));
        span = ($urandom_range(9) == 0) ? ALPHABET : $urandom_range(1, 4);
        base = $urandom_range(0, ALPHABET - span);
        pick = $urandom_range(99);
        if (pick < 8)
            plen = 0;
        else if (pick < 13)
            plen = $urandom_range(PATTERN_MAX - 4, PATTERN_MAX + 6);
        else
            plen = $urandom_range(1, 8);
        for (i = 0; i < plen; i++) begin
            swap = LETTER_W'(base + $urandom_range(span - 1));
            // letters past the maximum are dropped by the block
            if (i < PATTERN_MAX) pat.insert(pat.size(), swap);
            add_item(FUNC_PATTERN, swap, phase, 1'b0);
        end
        tlen = pat.size() + $urandom_range(2, 16);
        sent = 0;
        while (sent < tlen) begin
            pick = $urandom_range(99);
            if (pick < 40 && pat.size() != 0) begin
                for (i = pat.size() - 1; i > 0; i--) begin
                    j = $urandom_range(i);
                    swap = pat[i];
                    pat[i] = pat[j];
                    pat[j] = swap;
                end
                for (i = 0; i < pat.size(); i++) add_item(FUNC_TEXT, pat[i], phase, 1'b0);
                sent += pat.size();
            end else if (pick < 47) begin
                case ($urandom_range(2))
                    0: add_item(FUNC_TEXT, LETTER_W'($urandom_range(ALPHABET, 31)), phase, 1'b0);
                    1: add_item(FUNC_UNUSED, LETTER_W'($urandom_range(31)), phase, 1'b0);
                    default: add_item(FUNC_PATTERN, LETTER_W'($urandom_range(31)), phase, 1'b0);
                endcase
            end else begin
                add_item(FUNC_TEXT, LETTER_W'(base + $urandom_range(span - 1)), phase, 1'b0);
                sent++;
            end
        end
    endtask

    initial begin
        // empty pattern, invalid letters, unused func
        add_item(FUNC_TEXT, 5'd0, 0, 1'b0);
        add_item(FUNC_TEXT, 5'd31, 0, 1'b0);
        add_item(FUNC_UNUSED, 5'd31, 0, 1'b0);
        add_item(FUNC_CLEAR, 5'd31, 0, 1'b0);
        add_item(FUNC_PATTERN, 5'd0, 0, 1'b0);
        add_item(FUNC_PATTERN, 5'd25, 0, 1'b0);
        add_item(FUNC_PATTERN, 5'd31, 0, 1'b0);
        add_item(FUNC_UNUSED, 5'd5, 0, 1'b0);
        add_item(FUNC_TEXT, 5'd25, 0, 1'b0);
        add_item(FUNC_TEXT, 5'd0, 0, 1'b0);
        // late pattern letter is ignored
        add_item(FUNC_PATTERN, 5'd3, 0, 1'b0);
        add_item(FUNC_TEXT, 5'd0, 0, 1'b0);
        add_item(FUNC_TEXT, 5'd25, 0, 1'b0);
        add_item(FUNC_TEXT, 5'd26, 0, 1'b0);
        add_item(FUNC_TEXT, 5'd3, 0, 1'b0);
        add_item(FUNC_CLEAR, 5'd0, 0, 1'b0);
        add_item(FUNC_PATTERN, 5'd16, 0, 1'b0);
        add_item(FUNC_TEXT, 5'd15, 0, 1'b0);
        add_item(FUNC_TEXT, 5'd16, 0, 1'b0);
        add_item(FUNC_TEXT, 5'd16, 0, 1'b0);
        while (letter_q.size() < 620) add_sequence(0, 1'b0);
        add_sequence(1, 1'b1);
        while (letter_q.size() < 1240) add_sequence(1, 1'b0);
        add_sequence(2, 1'b1);
        while (letter_q.size() < 1860) add_sequence(2, 1'b0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (letter_q.size() != 0 || s_valid || verdict_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_400_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
